/* rtl/sdr_pkg.sv */
// shared constants for the spring distance relaxation block
// no dependencies; imported by the top level
package sdr_pkg;

   localparam int DEF_NUM_POINTS = 1024;
   localparam int IDX_W          = 10;
   localparam int POS_W          = 32;
   localparam int MASS_W         = 16;
   localparam int REST_W         = 31;
   localparam int STR_W          = 16;
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_RELAX = 2'd1;
   localparam logic [1:0] ACT_TEST  = 2'd2;
   localparam logic [1:0] ACT_READ  = 2'd3;

   localparam logic REG_WORLD_STRENGTH = 1'b0;
   localparam logic [STR_W-1:0] WORLD_STRENGTH_RESET = 16'd256;

endpackage

/* rtl/sdr_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module sdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/spring_distance_relax.sv */
// spring_distance_relax: point store with write, read, relax and break test of one spring
// channel protocol: valid/stall on request and response, apb-style csr port
// uses sdr_pkg and sdr_ram
//
// one request is worked on at a time; the response register lets the next request in
// while the previous response is still stalled.
// write point: written in the start state; read point: point a is read in the rdb state;
// both then raise the response from the fin state. break test and relax run the
// bit-serial multiplier (one multiplier bit per cycle, stops early on zero), the 33-step
// square root and, for a relax, the 64-step restoring divider, all sharing the datapath.
// points live in one ram of x, y and mass; the two ends are read one after the other
// and written back at the end of a relax, so requests never overlap on an entry.
// reset clears the control state and sets world_strength to 1.0; the ram is not cleared,
// so a point must be written before use.
// a stalled response holds its value; the block returns to idle once the response
// register is free and takes the next request in the following cycle.
// world_strength is written through psel/penable/pwrite at addresses 0 to 3 (paddr[2] low).
module spring_distance_relax #(
   parameter int NUM_POINTS = sdr_pkg::DEF_NUM_POINTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic [sdr_pkg::IDX_W-1:0]     req_index_a,
   input  logic [sdr_pkg::IDX_W-1:0]     req_index_b,
   input  logic signed [sdr_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [sdr_pkg::POS_W-1:0] req_pos_y,
   input  logic [sdr_pkg::MASS_W-1:0]    req_mass,
   input  logic [sdr_pkg::REST_W-1:0]    req_rest_length,
   input  logic [sdr_pkg::STR_W-1:0]     req_spring_strength,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [sdr_pkg::POS_W-1:0] rsp_read_x,
   output logic signed [sdr_pkg::POS_W-1:0] rsp_read_y,
   output logic                          rsp_broken,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sdr_pkg::CSR_AW-1:0]    paddr,
   input  logic [sdr_pkg::CSR_DW-1:0]    pwdata,
   output logic [sdr_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   import sdr_pkg::*;

   localparam int ADDR_W     = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
   localparam int WORD_W     = MASS_W + 2 * POS_W;
   localparam int WRAP_RECIP = ((1 << 20) + NUM_POINTS - 1) / NUM_POINTS;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_START = 5'd1;
   localparam logic [4:0] S_RDB   = 5'd2;
   localparam logic [4:0] S_DIFF  = 5'd3;
   localparam logic [4:0] S_SQX   = 5'd4;
   localparam logic [4:0] S_SQY   = 5'd5;
   localparam logic [4:0] S_SQRT  = 5'd6;
   localparam logic [4:0] S_LIM   = 5'd7;
   localparam logic [4:0] S_FAM   = 5'd8;
   localparam logic [4:0] S_FAD   = 5'd9;
   localparam logic [4:0] S_FBM   = 5'd10;
   localparam logic [4:0] S_FBD   = 5'd11;
   localparam logic [4:0] S_UXD   = 5'd12;
   localparam logic [4:0] S_UYD   = 5'd13;
   localparam logic [4:0] S_DAX   = 5'd14;
   localparam logic [4:0] S_DAY   = 5'd15;
   localparam logic [4:0] S_DBX   = 5'd16;
   localparam logic [4:0] S_DBY   = 5'd17;
   localparam logic [4:0] S_WRA   = 5'd18;
   localparam logic [4:0] S_WRB   = 5'd19;
   localparam logic [4:0] S_FIN   = 5'd20;

   function automatic logic [ADDR_W-1:0] wrap_index(input logic [IDX_W-1:0] idx);
      logic [29:0] prod;
      logic [9:0]  q;
      logic [20:0] r;
      prod = 30'(idx) * 30'(WRAP_RECIP);
      q    = prod[29:20];
      r    = 21'(idx) - 21'(q) * 21'(NUM_POINTS);
      if (r[20]) begin
         r = r + 21'(NUM_POINTS);
      end
      if (NUM_POINTS >= 1024) begin
         return ADDR_W'(idx);
      end
      return r[ADDR_W-1:0];
   endfunction

   function automatic logic [31:0] move_sat(input logic [31:0] pos, input logic [35:0] mag,
                                            input logic add);
      logic [37:0] p;
      logic [37:0] m;
      logic [37:0] s;
      p = {{6{pos[31]}}, pos};
      m = {2'b00, mag};
      s = add ? p + m : p - m;
      if (s[37:31] == {7{s[37]}}) begin
         return s[31:0];
      end else if (s[37]) begin
         return 32'h8000_0000;
      end
      return 32'h7fff_ffff;
   endfunction

   // control
   logic [4:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] ws_ff, ws_in;
   logic [6:0]  cnt_ff, cnt_in;

   // request fields
   logic [1:0]        act_ff, act_in;
   logic [IDX_W-1:0]  ia_ff, ia_in, ib_ff, ib_in;
   logic [31:0]       px_ff, px_in, py_ff, py_in;
   logic [15:0]       mass_ff, mass_in;
   logic [30:0]       rest_ff, rest_in;
   logic [15:0]       str_ff, str_in;

   // point data
   logic [31:0] xa_ff, xa_in, ya_ff, ya_in, xb_ff, xb_in, yb_ff, yb_in;
   logic [15:0] ma_ff, ma_in, mb_ff, mb_in;
   logic        ex_neg_ff, ex_neg_in, ey_neg_ff, ey_neg_in, corr_neg_ff, corr_neg_in;
   logic [32:0] mx_ff, mx_in, my_ff, my_in, dist_ff, dist_in;
   logic [19:0] tot_ff, tot_in;
   logic [32:0] lim_ff, lim_in;
   logic [33:0] corr_mag_ff, corr_mag_in;
   logic [34:0] fa_ff, fa_in, fb_ff, fb_in;
   logic [30:0] ux_ff, ux_in, uy_ff, uy_in;
   logic [35:0] dax_ff, dax_in, day_ff, day_in, dbx_ff, dbx_in, dby_ff, dby_in;

   // shared units
   logic [65:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [32:0] mplr_ff, mplr_in;
   logic [65:0] rad_ff, rad_in;
   logic [32:0] root_ff, root_in;
   logic [33:0] srem_ff, srem_in;
   logic [63:0] dnum_ff, dnum_in;
   logic [32:0] drem_ff, drem_in, dden_ff, dden_in;

   // results
   logic [31:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic        res_brk_ff, res_brk_in;
   logic [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic        out_brk_ff, out_brk_in;

   // step logic
   logic [65:0] mul_acc_step;
   logic [35:0] sq_rem_t, sq_trial;
   logic        sq_ge;
   logic [33:0] dv_t;
   logic        dv_ge;

   logic [ADDR_W-1:0] wa, wb;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;
   logic [31:0]       rd_x, rd_y;
   logic [15:0]       rd_m;

   logic [32:0] dx_c, dy_c;
   logic [32:0] mx_c, my_c;
   logic [34:0] corr_c;
   logic [33:0] corr_mag_c;
   logic [18:0] five_ma, five_mb;
   logic        mv_add;
   logic        csr_wr;

   sdr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NUM_POINTS)
   ) u_points (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_x = ram_rdata[31:0];
   assign rd_y = ram_rdata[63:32];
   assign rd_m = ram_rdata[79:64];

   assign wa = wrap_index(ia_ff);
   assign wb = wrap_index(ib_ff);

   assign dx_c = {rd_x[31], rd_x} - {xa_ff[31], xa_ff};
   assign dy_c = {rd_y[31], rd_y} - {ya_ff[31], ya_ff};
   assign mx_c = dx_c[32] ? 33'(-dx_c) : dx_c;
   assign my_c = dy_c[32] ? 33'(-dy_c) : dy_c;

   assign corr_c     = {4'b0, rest_ff} - {2'b0, root_ff};
   assign corr_mag_c = corr_c[34] ? 34'(-corr_c) : corr_c[33:0];
   assign five_ma    = {1'b0, ma_ff, 2'b00} + 19'(ma_ff);
   assign five_mb    = {1'b0, mb_ff, 2'b00} + 19'(mb_ff);
   assign mv_add     = ex_neg_ff ^ corr_neg_ff;

   assign mul_acc_step = mplr_ff[0] ? acc_ff + mcand_ff : acc_ff;
   assign sq_rem_t     = {srem_ff, rad_ff[65:64]};
   assign sq_trial     = {1'b0, root_ff, 2'b01};
   assign sq_ge        = sq_rem_t >= sq_trial;
   assign dv_t         = {drem_ff, dnum_ff[63]};
   assign dv_ge        = dv_t >= {1'b0, dden_ff};

   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_WORLD_STRENGTH);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ws_in        = ws_ff;
      cnt_in       = cnt_ff;
      act_in       = act_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      mass_in      = mass_ff;
      rest_in      = rest_ff;
      str_in       = str_ff;
      xa_in        = xa_ff;
      ya_in        = ya_ff;
      xb_in        = xb_ff;
      yb_in        = yb_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      ex_neg_in    = ex_neg_ff;
      ey_neg_in    = ey_neg_ff;
      corr_neg_in  = corr_neg_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      dist_in      = dist_ff;
      tot_in       = tot_ff;
      lim_in       = lim_ff;
      corr_mag_in  = corr_mag_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      ux_in        = ux_ff;
      uy_in        = uy_ff;
      dax_in       = dax_ff;
      day_in       = day_ff;
      dbx_in       = dbx_ff;
      dby_in       = dby_ff;
      mcand_in     = mcand_ff;
      acc_in       = acc_ff;
      mplr_in      = mplr_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      dnum_in      = dnum_ff;
      drem_in      = drem_ff;
      dden_in      = dden_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_brk_in   = res_brk_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_brk_in   = out_brk_ff;
      ram_we       = 1'b0;
      ram_waddr    = wa;
      ram_wdata    = {mass_ff, py_ff, px_ff};
      ram_raddr    = wa;

      if (csr_wr) begin
         ws_in = pwdata[15:0];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // bit-serial multiplier, stepping while multiplier bits remain
      if (mplr_ff != '0) begin
         acc_in   = mul_acc_step;
         mcand_in = {mcand_ff[64:0], 1'b0};
         mplr_in  = {1'b0, mplr_ff[32:1]};
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_action;
               ia_in    = req_index_a;
               ib_in    = req_index_b;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               mass_in  = req_mass;
               rest_in  = req_rest_length;
               str_in   = req_spring_strength;
               state_in = S_START;
            end
         end
         S_START: begin
            res_x_in   = '0;
            res_y_in   = '0;
            res_brk_in = 1'b0;
            if (act_ff == ACT_WRITE) begin
               ram_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            ram_raddr = wb;
            xa_in     = rd_x;
            ya_in     = rd_y;
            ma_in     = rd_m;
            if (act_ff == ACT_READ) begin
               res_x_in = rd_x;
               res_y_in = rd_y;
               state_in = S_FIN;
            end else begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            xb_in     = rd_x;
            yb_in     = rd_y;
            mb_in     = rd_m;
            ex_neg_in = dx_c[32];
            ey_neg_in = dy_c[32];
            mx_in     = mx_c;
            my_in     = my_c;
            tot_in    = 20'(five_ma) + {2'b0, rd_m, 2'b00};
            lim_in    = 33'(32'd65536) + 33'(32'(ws_ff) * 32'(str_ff));
            mcand_in  = 66'(mx_c);
            mplr_in   = mx_c;
            acc_in    = '0;
            state_in  = S_SQX;
         end
         S_SQX: begin
            if (mplr_ff == '0) begin
               rad_in   = acc_ff;
               mcand_in = 66'(my_ff);
               mplr_in  = my_ff;
               acc_in   = '0;
               state_in = S_SQY;
            end
         end
         S_SQY: begin
            if (mplr_ff == '0) begin
               rad_in   = rad_ff + acc_ff;
               root_in  = '0;
               srem_in  = '0;
               cnt_in   = 7'd33;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (cnt_ff != '0) begin
               srem_in = sq_ge ? 34'(sq_rem_t - sq_trial) : sq_rem_t[33:0];
               root_in = {root_ff[31:0], sq_ge};
               rad_in  = {rad_ff[63:0], 2'b00};
               cnt_in  = cnt_ff - 7'd1;
            end else begin
               dist_in = root_ff;
               if (act_ff == ACT_TEST) begin
                  mcand_in = 66'(lim_ff);
                  mplr_in  = 33'(rest_ff);
                  acc_in   = '0;
                  state_in = S_LIM;
               end else if (root_ff == '0 || tot_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  corr_neg_in = corr_c[34];
                  corr_mag_in = corr_mag_c;
                  mcand_in    = 66'(corr_mag_c);
                  mplr_in     = 33'(five_mb);
                  acc_in      = '0;
                  state_in    = S_FAM;
               end
            end
         end
         S_LIM: begin
            if (mplr_ff == '0) begin
               res_brk_in = 66'({dist_ff, 16'h0000}) > acc_ff;
               state_in   = S_FIN;
            end
         end
         S_FAM, S_FBM: begin
            if (mplr_ff == '0) begin
               dnum_in  = acc_ff[63:0];
               drem_in  = '0;
               dden_in  = 33'(tot_ff);
               cnt_in   = 7'd64;
               state_in = (state_ff == S_FAM) ? S_FAD : S_FBD;
            end
         end
         S_FAD, S_FBD, S_UXD, S_UYD: begin
            if (cnt_ff != '0) begin
               drem_in = dv_ge ? 33'(dv_t - {1'b0, dden_ff}) : dv_t[32:0];
               dnum_in = {dnum_ff[62:0], dv_ge};
               cnt_in  = cnt_ff - 7'd1;
            end else begin
               drem_in = '0;
               cnt_in  = 7'd64;
               dden_in = dist_ff;
               if (state_ff == S_FAD) begin
                  fa_in    = dnum_ff[34:0];
                  mcand_in = 66'(corr_mag_ff);
                  mplr_in  = 33'(five_ma);
                  acc_in   = '0;
                  state_in = S_FBM;
               end else if (state_ff == S_FBD) begin
                  fb_in    = dnum_ff[34:0];
                  dnum_in  = {1'b0, mx_ff, 30'd0};
                  state_in = S_UXD;
               end else if (state_ff == S_UXD) begin
                  ux_in    = dnum_ff[30:0];
                  dnum_in  = {1'b0, my_ff, 30'd0};
                  state_in = S_UYD;
               end else begin
                  uy_in    = dnum_ff[30:0];
                  mcand_in = 66'(fa_ff);
                  mplr_in  = 33'(ux_ff);
                  acc_in   = '0;
                  state_in = S_DAX;
               end
            end
         end
         S_DAX: begin
            if (mplr_ff == '0) begin
               dax_in   = acc_ff[65:30];
               mcand_in = 66'(fa_ff);
               mplr_in  = 33'(uy_ff);
               acc_in   = '0;
               state_in = S_DAY;
            end
         end
         S_DAY: begin
            if (mplr_ff == '0) begin
               day_in   = acc_ff[65:30];
               mcand_in = 66'(fb_ff);
               mplr_in  = 33'(ux_ff);
               acc_in   = '0;
               state_in = S_DBX;
            end
         end
         S_DBX: begin
            if (mplr_ff == '0) begin
               dbx_in   = acc_ff[65:30];
               mcand_in = 66'(fb_ff);
               mplr_in  = 33'(uy_ff);
               acc_in   = '0;
               state_in = S_DBY;
            end
         end
         S_DBY: begin
            if (mplr_ff == '0) begin
               dby_in   = acc_ff[65:30];
               state_in = S_WRA;
            end
         end
         S_WRA: begin
            ram_we    = 1'b1;
            ram_waddr = wa;
            ram_wdata = {ma_ff,
                         move_sat(ya_ff, day_ff, ey_neg_ff ^ corr_neg_ff),
                         move_sat(xa_ff, dax_ff, mv_add)};
            state_in  = S_WRB;
         end
         S_WRB: begin
            ram_we    = 1'b1;
            ram_waddr = wb;
            ram_wdata = {mb_ff,
                         move_sat(yb_ff, dby_ff, !(ey_neg_ff ^ corr_neg_ff)),
                         move_sat(xb_ff, dbx_ff, !mv_add)};
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_x_in     = res_x_ff;
               out_y_in     = res_y_ff;
               out_brk_in   = res_brk_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ws_ff        <= WORLD_STRENGTH_RESET;
         cnt_ff       <= '0;
         mplr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ws_ff        <= ws_in;
         cnt_ff       <= cnt_in;
         mplr_ff      <= mplr_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      mass_ff     <= mass_in;
      rest_ff     <= rest_in;
      str_ff      <= str_in;
      xa_ff       <= xa_in;
      ya_ff       <= ya_in;
      xb_ff       <= xb_in;
      yb_ff       <= yb_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      ex_neg_ff   <= ex_neg_in;
      ey_neg_ff   <= ey_neg_in;
      corr_neg_ff <= corr_neg_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      dist_ff     <= dist_in;
      tot_ff      <= tot_in;
      lim_ff      <= lim_in;
      corr_mag_ff <= corr_mag_in;
      fa_ff       <= fa_in;
      fb_ff       <= fb_in;
      ux_ff       <= ux_in;
      uy_ff       <= uy_in;
      dax_ff      <= dax_in;
      day_ff      <= day_in;
      dbx_ff      <= dbx_in;
      dby_ff      <= dby_in;
      mcand_ff    <= mcand_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      dnum_ff     <= dnum_in;
      drem_ff     <= drem_in;
      dden_ff     <= dden_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_brk_ff  <= res_brk_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_brk_ff  <= out_brk_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_read_x = out_x_ff;
   assign rsp_read_y = out_y_ff;
   assign rsp_broken = out_brk_ff;
   assign pready     = 1'b1;
   assign prdata     = (paddr[2] == REG_WORLD_STRENGTH) ? {16'h0000, ws_ff} : '0;

`ifndef SYNTHESIS
   // ram writes only from a point write or the two write-backs of a relax
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_START || state_ff == S_WRA || state_ff == S_WRB))
      else $error("point store written outside a write state");

   // a relax that writes back never has both ends on one entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRA) |-> (wa != wb))
      else $error("relax write-back on coincident points");

   // divider never runs with a zero denominator
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FAD || state_ff == S_FBD || state_ff == S_UXD || state_ff == S_UYD)
      |-> (dden_ff != '0))
      else $error("divide by zero");

   // only a break test reports a broken spring
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && res_brk_ff) |-> (act_ff == ACT_TEST))
      else $error("broken flag on a non-test request");
`endif

endmodule
